### rtl/olbe_pkg.sv
// Shared types and codes for the ordered list engine.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.

package olbe_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_REMOVE     = 3'd4,
      ACT_CONTAINS   = 3'd5,
      ACT_PEEK_FRONT = 3'd6,
      ACT_PEEK_BACK  = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef logic [5:0] count_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               found;
      status_type         status;
      count_type          count_after;
      logic               is_empty;
   } rsp_type;

   // Operation broadcast to every cell of the chain at once.
   typedef struct packed {
      logic capture;
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
      logic remove;
   } cell_op_type;

endpackage

### rtl/olbe_cell.sv
// One position of the ordered list: a stored value, its valid flag and a match flag.
// Depends on olbe_pkg for the broadcast operation struct.

module olbe_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  olbe_pkg::cell_op_type     op,
   input  logic signed [31:0]        key,
   input  logic signed [31:0]        left_value,
   input  logic                      left_valid,
   input  logic signed [31:0]        right_value,
   input  logic                      right_valid,
   input  logic                      hit_in,
   output logic signed [31:0]        value,
   output logic                      valid,
   output logic                      hit_out,
   output logic                      last
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               match_ff, match_in;

   assign value   = value_ff;
   assign valid   = valid_ff;
   assign hit_out = hit_in | match_ff;
   assign last    = valid_ff & ~right_valid;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (op.capture) begin
         match_in = valid_ff && (value_ff == key);
      end
      if (op.push_front) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (op.push_back) begin
         // The first empty position takes the new entry.
         if (!valid_ff && left_valid) begin
            value_in = key;
            valid_in = 1'b1;
         end
      end else if (op.pop_front || (op.remove && hit_out)) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (op.pop_back) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### rtl/ordered_list_bag_engine_top.sv
// Top level of the ordered list engine: control, entry count and the chain of cells.
// Depends on olbe_pkg and olbe_cell.
//
// Usage:
//   A request beat is taken at a rising edge where start is high and busy is
//   low; req_data carries the action and the value. Every request gives one
//   response beat on rsp_data, marked by rsp_strobe for exactly one cycle.
//   The receiver cannot hold responses off, and none is ever needed: the
//   response is registered and stands alone on the port for its one cycle.
//   An accepted request moves into the EXEC state, and its response is then
//   registered; no new request is taken during EXEC. In the cycle after the accept
//   every cell has registered its own compare against the key; in that same
//   cycle the first-match chain through the cells settles and the cells that
//   change shift, load or clear together. busy is high during that one cycle.
//   Reset clears all valid flags and the entry count, so the list is empty;
//   no clearing pass is needed and the block takes a request right after.
//   count_after carries the low six bits of the entry count.

module ordered_list_bag_engine_top #(
   parameter int CAPACITY = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  olbe_pkg::req_type req_data,
   output logic              rsp_strobe,
   output olbe_pkg::rsp_type rsp_data
);

   localparam int CountW = $clog2(CAPACITY + 1);

   olbe_pkg::state_type   state_ff, state_in;
   olbe_pkg::req_type     req_ff, req_in;
   olbe_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CountW-1:0]     count_ff, count_in;
   olbe_pkg::cell_op_type op;
   logic signed [31:0]    key;

   logic signed [31:0] value_w [CAPACITY];
   logic               valid_w [CAPACITY];
   logic               hit_w   [CAPACITY];
   logic               last_w  [CAPACITY];
   logic signed [31:0] back_w  [CAPACITY];

   logic signed [31:0] front_value;
   logic signed [31:0] back_value;
   logic               any_hit;
   logic               full;
   logic               empty;

   assign front_value = value_w[0];
   assign back_value  = back_w[CAPACITY-1];
   assign any_hit     = hit_w[CAPACITY-1];
   assign full        = (count_ff == CountW'(CAPACITY));
   assign empty       = (count_ff == '0);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [31:0] left_value, right_value;
         logic               left_valid, right_valid, hit_in;

         if (gi == 0) begin : g_head
            // The head sees the key as its left neighbor, for push at the front.
            assign left_value = key;
            assign left_valid = 1'b1;
            assign hit_in     = 1'b0;
            assign back_w[gi] = last_w[gi] ? value_w[gi] : '0;
         end else begin : g_body
            assign left_value = value_w[gi-1];
            assign left_valid = valid_w[gi-1];
            assign hit_in     = hit_w[gi-1];
            assign back_w[gi] = back_w[gi-1] | (last_w[gi] ? value_w[gi] : '0);
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
         end else begin : g_inner
            assign right_value = value_w[gi+1];
            assign right_valid = valid_w[gi+1];
         end

         olbe_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (op),
            .key         (key),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .right_value (right_value),
            .right_valid (right_valid),
            .hit_in      (hit_in),
            .value       (value_w[gi]),
            .valid       (valid_w[gi]),
            .hit_out     (hit_w[gi]),
            .last        (last_w[gi])
         );
      end
   endgenerate

   always_comb begin
      logic signed [31:0]   res;
      logic                 found;
      olbe_pkg::status_type status;

      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      count_in     = count_ff;
      op           = '0;
      busy         = 1'b1;
      key          = req_ff.value;
      res          = '0;
      found        = 1'b0;
      status       = olbe_pkg::STATUS_OK;

      case (state_ff)
         olbe_pkg::ST_IDLE: begin
            busy = 1'b0;
            key  = req_data.value;
            if (start) begin
               req_in     = req_data;
               op.capture = 1'b1;
               state_in   = olbe_pkg::ST_EXEC;
            end
         end
         olbe_pkg::ST_EXEC: begin
            case (req_ff.action)
               olbe_pkg::ACT_PUSH_FRONT, olbe_pkg::ACT_PUSH_BACK: begin
                  if (full) begin
                     status = olbe_pkg::STATUS_FULL;
                  end else begin
                     op.push_front = (req_ff.action == olbe_pkg::ACT_PUSH_FRONT);
                     op.push_back  = (req_ff.action == olbe_pkg::ACT_PUSH_BACK);
                     count_in      = count_ff + CountW'(1);
                  end
               end
               olbe_pkg::ACT_POP_FRONT, olbe_pkg::ACT_PEEK_FRONT: begin
                  if (empty) begin
                     status = olbe_pkg::STATUS_EMPTY;
                  end else begin
                     res = front_value;
                     if (req_ff.action == olbe_pkg::ACT_POP_FRONT) begin
                        op.pop_front = 1'b1;
                        count_in     = count_ff - CountW'(1);
                     end
                  end
               end
               olbe_pkg::ACT_POP_BACK, olbe_pkg::ACT_PEEK_BACK: begin
                  if (empty) begin
                     status = olbe_pkg::STATUS_EMPTY;
                  end else begin
                     res = back_value;
                     if (req_ff.action == olbe_pkg::ACT_POP_BACK) begin
                        op.pop_back = 1'b1;
                        count_in    = count_ff - CountW'(1);
                     end
                  end
               end
               olbe_pkg::ACT_REMOVE, olbe_pkg::ACT_CONTAINS: begin
                  if (empty) begin
                     status = olbe_pkg::STATUS_EMPTY;
                  end else if (!any_hit) begin
                     status = olbe_pkg::STATUS_NOT_FOUND;
                  end else begin
                     found = 1'b1;
                     res   = req_ff.value;
                     if (req_ff.action == olbe_pkg::ACT_REMOVE) begin
                        op.remove = 1'b1;
                        count_in  = count_ff - CountW'(1);
                     end
                  end
               end
               default: begin
                  status = olbe_pkg::STATUS_OK;
               end
            endcase
            rsp_in.result_value = res;
            rsp_in.found        = found;
            rsp_in.status       = status;
            rsp_in.count_after  = olbe_pkg::count_type'(count_in);
            rsp_in.is_empty     = (count_in == '0);
            rsp_valid_in        = 1'b1;
            state_in            = olbe_pkg::ST_IDLE;
         end
         default: begin
            state_in = olbe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

### rtl/olbe_checker.sv
// Port-level checks for the ordered list engine, attached to the top level by bind.
// Depends on olbe_pkg and on the ports of ordered_list_bag_engine_top.

module olbe_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input olbe_pkg::req_type req_data,
   input logic              rsp_strobe,
   input olbe_pkg::rsp_type rsp_data
);

   // Every accepted request beat yields its response beat.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("request beat without its response beat");

   // A response beat is never shown while a request is still being worked on.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response beat while busy");

   // A match is only reported with a success status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.found) |-> (rsp_data.status == olbe_pkg::STATUS_OK))
      else $error("found flag with a failure status");

   // An empty-list failure leaves an empty list and returns no value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == olbe_pkg::STATUS_EMPTY)
         |-> (rsp_data.is_empty && rsp_data.result_value == '0 && !rsp_data.found))
      else $error("empty status with a nonempty list or a value");

endmodule

bind ordered_list_bag_engine_top olbe_checker u_olbe_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
